### rtl/s3264_pkg.sv
// ----------------------------------------------------------------------------
// SIMON32/64 package
// Shared types, constants and round/key-schedule functions.
// ----------------------------------------------------------------------------
package s3264_pkg;

  localparam int WORD_W         = 16;
  localparam int CNT_W          = 6;
  localparam int MAX_ROUNDS_DEF = 32;
  localparam int Z_LEN          = 62;
  localparam int CFG_AW         = 5;
  localparam int CFG_DW         = 32;

  localparam logic [Z_LEN-1:0] Z0_SEQ = 62'h3E8958737D12B0E6;

  localparam logic [CNT_W-1:0] ROUNDS_RST = 6'd32;

  // register index codes (paddr[4:2])
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_ROUNDS = 3'd4;

  typedef logic [WORD_W-1:0] word_t;

  // block state plus sliding window of four round keys, k0 is this round's key
  typedef struct packed {
    word_t x;
    word_t y;
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } cell_data_t;

  function automatic word_t rol(input word_t v, input int s);
    rol = (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic word_t ror(input word_t v, input int s);
    ror = (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic word_t round_f(input word_t x);
    round_f = (rol(x, 1) & rol(x, 8)) ^ rol(x, 2);
  endfunction

  function automatic logic z0_bit(input int idx);
    z0_bit = Z0_SEQ[Z_LEN-1-idx];
  endfunction

  // next round key from the window, zb is the z0 sequence bit for this position
  function automatic word_t key_next(input cell_data_t d, input logic zb);
    word_t t;
    t = ror(d.k3, 3) ^ d.k1;
    t = t ^ ror(t, 1);
    key_next = ~d.k0 ^ t ^ {{(WORD_W-1){1'b0}}, zb} ^ word_t'(3);
  endfunction

endpackage

### rtl/s3264_in_if.sv
// ----------------------------------------------------------------------------
// SIMON32/64 plaintext channel
// Valid/ready stream carrying one plaintext block per transaction.
// ----------------------------------------------------------------------------
interface s3264_in_if;
  logic              valid;
  logic              ready;
  s3264_pkg::word_t  plain_left;
  s3264_pkg::word_t  plain_right;

  modport source (output valid, output plain_left, output plain_right, input ready);
  modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

### rtl/s3264_out_if.sv
// ----------------------------------------------------------------------------
// SIMON32/64 ciphertext channel
// Valid/ready stream carrying one ciphertext block per transaction.
// ----------------------------------------------------------------------------
interface s3264_out_if;
  logic              valid;
  logic              ready;
  s3264_pkg::word_t  cipher_left;
  s3264_pkg::word_t  cipher_right;

  modport source (output valid, output cipher_left, output cipher_right, input ready);
  modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

### rtl/s3264_cell.sv
// ----------------------------------------------------------------------------
// SIMON32/64 round cell, registered, elastic handshake
// Feistel round while IDX < round_cnt, plus one key-schedule step.
// ----------------------------------------------------------------------------
module s3264_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [s3264_pkg::CNT_W-1:0]       round_cnt,
  input  logic                              up_vld,
  input  s3264_pkg::cell_data_t             up_dat,
  output logic                              up_rdy,
  output logic                              dn_vld,
  output s3264_pkg::cell_data_t             dn_dat,
  input  logic                              dn_rdy
);

  logic                  vld_r;
  s3264_pkg::cell_data_t dat_r;
  s3264_pkg::cell_data_t dat_nxt;
  logic                  active;

  assign active = s3264_pkg::CNT_W'(IDX) < round_cnt;
  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    dat_nxt    = up_dat;
    if (active) begin
      dat_nxt.x = up_dat.y ^ s3264_pkg::round_f(up_dat.x) ^ up_dat.k0;
      dat_nxt.y = up_dat.x;
    end
    dat_nxt.k0 = up_dat.k1;
    dat_nxt.k1 = up_dat.k2;
    dat_nxt.k2 = up_dat.k3;
    dat_nxt.k3 = s3264_pkg::key_next(up_dat, s3264_pkg::z0_bit(IDX));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      dat_r <= dat_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_dat = dat_r;

endmodule

### rtl/simon32_64_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// SIMON32/64 block encryption unit
// One registered cell per round stands between input transaction and result.
// Throughput: one block per cycle without output stalls; each cell carries its
//   own key window, so key writes take effect for the very next block.
// Each cell stage has its own ready, so bubbles collapse and the last cell
//   is the output register.
// Reset (synchronous, rst_n low): key words 0, round count 32, pipeline empty.
// ----------------------------------------------------------------------------
module simon32_64_block_encrypt_unit #(
  parameter int MAX_ROUNDS = s3264_pkg::MAX_ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  s3264_in_if.sink                          in_ch,
  s3264_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [s3264_pkg::CFG_AW-1:0]      paddr,
  input  logic [s3264_pkg::CFG_DW-1:0]      pwdata,
  output logic [s3264_pkg::CFG_DW-1:0]      prdata,
  output logic                              pready
);

  s3264_pkg::word_t                 key_r [4];
  logic [s3264_pkg::CNT_W-1:0]      round_cnt_r;
  logic                             cfg_wr;
  logic [2:0]                       cfg_idx;

  logic [MAX_ROUNDS:0]              stage_vld;
  logic [MAX_ROUNDS:0]              stage_rdy;
  s3264_pkg::cell_data_t            stage_dat [MAX_ROUNDS+1];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]    <= '0;
      key_r[1]    <= '0;
      key_r[2]    <= '0;
      key_r[3]    <= '0;
      round_cnt_r <= s3264_pkg::ROUNDS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        s3264_pkg::REG_KEY0:   key_r[0]    <= pwdata[15:0];
        s3264_pkg::REG_KEY1:   key_r[1]    <= pwdata[15:0];
        s3264_pkg::REG_KEY2:   key_r[2]    <= pwdata[15:0];
        s3264_pkg::REG_KEY3:   key_r[3]    <= pwdata[15:0];
        s3264_pkg::REG_ROUNDS: round_cnt_r <= pwdata[s3264_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      s3264_pkg::REG_KEY0:   prdata = {16'd0, key_r[0]};
      s3264_pkg::REG_KEY1:   prdata = {16'd0, key_r[1]};
      s3264_pkg::REG_KEY2:   prdata = {16'd0, key_r[2]};
      s3264_pkg::REG_KEY3:   prdata = {16'd0, key_r[3]};
      s3264_pkg::REG_ROUNDS: prdata = {26'd0, round_cnt_r};
      default:               prdata = '0;
    endcase
  end

  // head of the chain
  assign stage_vld[0]    = in_ch.valid;
  assign in_ch.ready     = stage_rdy[0];
  assign stage_dat[0].x  = in_ch.plain_left;
  assign stage_dat[0].y  = in_ch.plain_right;
  assign stage_dat[0].k0 = key_r[0];
  assign stage_dat[0].k1 = key_r[1];
  assign stage_dat[0].k2 = key_r[2];
  assign stage_dat[0].k3 = key_r[3];

  for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_cell
    s3264_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_cnt (round_cnt_r),
      .up_vld    (stage_vld[g]),
      .up_dat    (stage_dat[g]),
      .up_rdy    (stage_rdy[g]),
      .dn_vld    (stage_vld[g+1]),
      .dn_dat    (stage_dat[g+1]),
      .dn_rdy    (stage_rdy[g+1])
    );
  end

  // tail of the chain
  assign stage_rdy[MAX_ROUNDS] = out_ch.ready;
  assign out_ch.valid          = stage_vld[MAX_ROUNDS];
  assign out_ch.cipher_left    = stage_dat[MAX_ROUNDS].x;
  assign out_ch.cipher_right   = stage_dat[MAX_ROUNDS].y;

`ifndef NO_ASSERTIONS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> &stage_vld[MAX_ROUNDS:1])
    else $error("input stalled with a free cell in the chain");

  a_cell_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage_vld[1] && !stage_rdy[1] |=> stage_vld[1] && $stable(stage_dat[1]))
    else $error("stalled cell lost or changed its transaction");

  a_rounds_reset: assert property (@(posedge clk)
    !rst_n |=> round_cnt_r == s3264_pkg::ROUNDS_RST)
    else $error("round count not restored by reset");

  a_key0_write: assert property (@(posedge clk)
    rst_n && cfg_wr && cfg_idx == s3264_pkg::REG_KEY0 |=> key_r[0] == $past(pwdata[15:0]))
    else $error("key word write not taken");
`endif

endmodule

### bench/simon32_64_block_encrypt_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIMON32/64 block encrypt unit testbench
// Writes key words and round counts over the APB port while the pipeline is
// empty. Directed blocks come first, then random blocks under each key and
// round setting. A queue-fed driver and a monitor with random stalls stand on
// the two channels. Each ciphertext is checked against an in-bench cipher
// model.
// ----------------------------------------------------------------------------
module simon32_64_block_encrypt_unit_tb;

  localparam int MAX_RND   = 32;
  localparam int LIMIT     = 400000;
  localparam int N_PHASES  = 14;
  localparam int PHASE_LEN = 100;
  localparam logic [61:0] Z0 = 62'h3E8958737D12B0E6;

  typedef struct packed {
    s3264_pkg::word_t left;
    s3264_pkg::word_t right;
  } block_t;

  logic clk;
  logic rst_n;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [s3264_pkg::CFG_AW-1:0] paddr;
  logic [s3264_pkg::CFG_DW-1:0] pwdata;
  logic [s3264_pkg::CFG_DW-1:0] prdata;
  logic                         pready;

  s3264_in_if  in_bus ();
  s3264_out_if out_bus ();

  simon32_64_block_encrypt_unit #(
    .MAX_ROUNDS(MAX_RND)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // mirror of the register file and key schedule
  s3264_pkg::word_t key_reg [4];
  s3264_pkg::word_t sched_key [MAX_RND];
  logic [5:0]       round_reg;

  block_t plain_pending [$];
  block_t cipher_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int cycles = 0;

  function automatic s3264_pkg::word_t rotl16(input s3264_pkg::word_t v, input int s);
    return (v << s) | (v >> (16 - s));
  endfunction

  function automatic s3264_pkg::word_t rotr16(input s3264_pkg::word_t v, input int s);
    return (v >> s) | (v << (16 - s));
  endfunction

  function automatic void expand_schedule();
    s3264_pkg::word_t t;
    for (int i = 0; i < 4; i++) sched_key[i] = key_reg[i];
    for (int i = 4; i < MAX_RND; i++) begin
      t = rotr16(sched_key[i-1], 3) ^ sched_key[i-3];
      t = t ^ rotr16(t, 1);
      sched_key[i] = ~sched_key[i-4] ^ t ^ s3264_pkg::word_t'(Z0[61-((i-4)%62)]) ^
                     s3264_pkg::word_t'(3);
    end
  endfunction

  function automatic block_t simon_encrypt(input s3264_pkg::word_t pl,
                                           input s3264_pkg::word_t pr);
    s3264_pkg::word_t x;
    s3264_pkg::word_t y;
    s3264_pkg::word_t nx;
    int               n;
    x = pl;
    y = pr;
    n = (round_reg > MAX_RND) ? MAX_RND : int'(round_reg);
    for (int i = 0; i < n; i++) begin
      nx = y ^ ((rotl16(x, 1) & rotl16(x, 8)) ^ rotl16(x, 2)) ^ sched_key[i];
      y  = x;
      x  = nx;
    end
    return '{left: x, right: y};
  endfunction

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    block_t blk;
    bit     send;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        cipher_due.push_back(simon_encrypt(in_bus.plain_left, in_bus.plain_right));
      if (!in_bus.valid || in_bus.ready) begin
        send = (plain_pending.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
        if (send) begin
          blk = plain_pending.pop_front();
          in_bus.plain_left  <= blk.left;
          in_bus.plain_right <= blk.right;
        end
        in_bus.valid <= send;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    block_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (cipher_due.size() == 0) begin
          $error("unexpected transaction: cipher_left %h cipher_right %h",
                 out_bus.cipher_left, out_bus.cipher_right);
          errors++;
        end else begin
          want = cipher_due.pop_front();
          if (out_bus.cipher_left !== want.left) begin
            $error("cipher_left expected %h actual %h", want.left, out_bus.cipher_left);
            errors++;
          end
          if (out_bus.cipher_right !== want.right) begin
            $error("cipher_right expected %h actual %h", want.right, out_bus.cipher_right);
            errors++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    logic [s3264_pkg::CFG_DW-1:0] data;
    data = $urandom;
    if (idx == s3264_pkg::REG_ROUNDS) data[5:0] = val[5:0];
    else data[15:0] = val;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      s3264_pkg::REG_KEY0, s3264_pkg::REG_KEY1,
      s3264_pkg::REG_KEY2, s3264_pkg::REG_KEY3: begin
        key_reg[idx[1:0]] = data[15:0];
        expand_schedule();
      end
      s3264_pkg::REG_ROUNDS: round_reg = data[5:0];
      default: ;
    endcase
  endtask

  task automatic set_key(input s3264_pkg::word_t k0, input s3264_pkg::word_t k1,
                         input s3264_pkg::word_t k2, input s3264_pkg::word_t k3);
    cfg_write(s3264_pkg::REG_KEY0, k0);
    cfg_write(s3264_pkg::REG_KEY1, k1);
    cfg_write(s3264_pkg::REG_KEY2, k2);
    cfg_write(s3264_pkg::REG_KEY3, k3);
  endtask

  task automatic queue_block(input s3264_pkg::word_t l, input s3264_pkg::word_t r);
    plain_pending.push_back('{left: l, right: r});
  endtask

  // wait until every block has been sent and its ciphertext seen
  task automatic drain();
    do @(negedge clk);
    while (plain_pending.size() != 0 || in_bus.valid || cipher_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 26; recv_idle_pct = 66; end
      1: begin send_idle_pct = 66; recv_idle_pct = 26; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  initial begin
    s3264_pkg::word_t l;
    s3264_pkg::word_t r;
    logic [5:0]       nr;
    int               sel;

    clk                 = 1'b0;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_bus.valid        = 1'b0;
    in_bus.plain_left   = '0;
    in_bus.plain_right  = '0;
    out_bus.ready       = 1'b0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    round_reg = s3264_pkg::ROUNDS_RST;
    expand_schedule();
    set_idle(0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset key, full rounds
    queue_block(16'h0000, 16'h0000);
    queue_block(16'hFFFF, 16'hFFFF);
    queue_block(16'h0000, 16'hFFFF);
    queue_block(16'hFFFF, 16'h0000);
    queue_block(16'h8000, 16'h0001);
    drain();

    // published test vector key
    set_key(16'h0100, 16'h0908, 16'h1110, 16'h1918);
    cfg_write(s3264_pkg::REG_ROUNDS, 6'd32);
    queue_block(16'h6565, 16'h6877);
    queue_block(16'h0001, 16'h8000);
    queue_block(16'hAAAA, 16'h5555);
    drain();

    // zero rounds: pass-through
    cfg_write(s3264_pkg::REG_ROUNDS, 6'd0);
    queue_block(16'h1234, 16'hABCD);
    queue_block(16'hFFFF, 16'h0000);
    drain();

    cfg_write(s3264_pkg::REG_ROUNDS, 6'd1);
    queue_block(16'h6565, 16'h6877);
    queue_block(16'h0000, 16'h0000);
    drain();

    // above the maximum: saturates
    cfg_write(s3264_pkg::REG_ROUNDS, 6'd63);
    queue_block(16'h6565, 16'h6877);
    queue_block(16'hFFFF, 16'hFFFF);
    drain();

    cfg_write(s3264_pkg::REG_ROUNDS, 6'd33);
    queue_block(16'h6565, 16'h6877);
    drain();

    // key change, then blocks queued back to back
    set_key(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cfg_write(s3264_pkg::REG_ROUNDS, 6'd31);
    queue_block(16'h0000, 16'h0000);
    queue_block(16'hFFFF, 16'hFFFF);
    queue_block(16'h5A5A, 16'hA5A5);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_idle(p * 3 / N_PHASES);
      case (p)
        0: set_key(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: set_key(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_key(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      case (p % 7)
        0: nr = 6'd32;
        1: nr = 6'd1;
        2: nr = 6'd0;
        3: nr = 6'd63;
        4: nr = 6'($urandom_range(2, 31));
        5: nr = 6'd33;
        default: nr = 6'($urandom_range(0, 63));
      endcase
      cfg_write(s3264_pkg::REG_ROUNDS, nr);
      for (int i = 0; i < PHASE_LEN; i++) begin
        l   = 16'($urandom);
        r   = 16'($urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0) l = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (sel == 1) r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        queue_block(l, r);
      end
      drain();
    end

    repeat (MAX_RND + 8) @(posedge clk);
    if (errors == 0 && cipher_due.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
